// ----- rtl/sda_pkg.sv -----
`timescale 1ns / 1ps

package sda_pkg;

  // defaults for the top-level parameters
  localparam int COORD_WIDTH_DEF   = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  // CORDIC datapath: x/y carry the normalized vector plus gain growth
  localparam int XW       = 36;
  // normalized coordinate width (magnitude kept below 2^31)
  localparam int NW       = 32;
  // angle accumulator, 1/32768 degree
  localparam int ZW       = 24;
  localparam int AZ_W     = 16;
  localparam int POL_W    = 15;
  // accumulator fraction bits dropped on output (1/32768 -> 1/128 degree)
  localparam int ANG_FRAC = ZW - AZ_W;
  localparam int NORM_TOP = 30;
  localparam int TAB_LEN  = 24;

  localparam logic signed [ZW-1:0]   DEG90    = 24'sd2949120;
  localparam logic signed [ZW-1:0]   RND_HALF = 24'sd128;
  localparam logic signed [AZ_W-1:0] AZ_MAX   = 16'sd23040;
  localparam logic signed [AZ_W-1:0] AZ_MIN   = -16'sd23040;
  localparam logic [POL_W-1:0]       POL_MAX  = 15'd23040;
  // CORDIC gain in Q16
  localparam logic [16:0]            K_Q16    = 17'd107923;

  // atan(2^-i) in degrees * 32768, rounded
  localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
    24'sd1474560, 24'sd870484, 24'sd459940, 24'sd233473,
    24'sd117189,  24'sd58652,  24'sd29333,  24'sd14667,
    24'sd7334,    24'sd3667,   24'sd1833,   24'sd917,
    24'sd458,     24'sd229,    24'sd115,    24'sd57,
    24'sd29,      24'sd14,     24'sd7,      24'sd4,
    24'sd2,       24'sd1,      24'sd0,      24'sd0
  };

  // vector state of one CORDIC step
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } sda_vec_t;

  // per-segment status carried alongside the datapath
  typedef struct packed {
    logic degen;  // zero-length segment
    logic axis;   // dx == dy == 0
    logic dzneg;  // dz < 0
  } sda_flags_t;

  // move a left-half-plane vector into the right half plane by +-90 degrees
  function automatic sda_vec_t prerot(logic signed [XW-1:0] x, logic signed [XW-1:0] y);
    sda_vec_t v;
    if (x[XW-1]) begin
      if (!y[XW-1]) begin
        v.x = y;
        v.y = -x;
        v.z = DEG90;
      end else begin
        v.x = -y;
        v.y = x;
        v.z = -DEG90;
      end
    end else begin
      v.x = x;
      v.y = y;
      v.z = '0;
    end
    return v;
  endfunction

  // round half up from 1/32768 to 1/128 degree
  function automatic logic signed [AZ_W-1:0] round_deg(logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    t = z + RND_HALF;
    return AZ_W'(t >>> ANG_FRAC);
  endfunction

endpackage

// ----- rtl/segment_direction_angles_unit.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Signals                    Transaction
// s_axis    in   tvalid, tready, tdata      one segment (two end points)
// m_axis    out  tvalid, tready, tdata, tuser  midpoint sums, azimuth, polar
//
// Accepts one segment per cycle when unstalled; each result passes through
// the five front stages, the two CORDIC cell rows, the bridge stage between
// the rows and the output register after them.
// Every stage has its own valid bit; a stall at m_axis fills empty stages first.
// Reset clears all valid bits; no clearing pass.

module segment_direction_angles_unit #(
  parameter int COORD_WIDTH   = sda_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = sda_pkg::CORDIC_STAGES_DEF,
  localparam int IN_DW  = ((6 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((3 * (COORD_WIDTH + 1) + sda_pkg::AZ_W + sda_pkg::POL_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // first_x, first_y, first_z, second_x, second_y, second_z, zero pad
  input  logic [IN_DW-1:0]  s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // mid_x, mid_y, mid_z, azimuth, polar, zero pad
  output logic [OUT_DW-1:0] m_axis_tdata_o,
  // degenerate
  output logic              m_axis_tuser_o
);
  import sda_pkg::*;

  localparam int MW     = COORD_WIDTH + 1;
  localparam int FL_W   = $bits(sda_flags_t);
  localparam int SB_AZ  = XW + 3 * MW + FL_W;
  localparam int SB_POL = AZ_W + 3 * MW + FL_W;

  // front end
  logic                 fr_valid, fr_ready;
  sda_vec_t             fr_vec;
  logic signed [XW-1:0] fr_zk;
  logic [3*MW-1:0]      fr_mid;
  sda_flags_t           fr_flags;

  // azimuth cell row
  sda_vec_t          az_vec [CORDIC_STAGES+1];
  logic [SB_AZ-1:0]  az_sb  [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] az_v, az_r;
  logic signed [XW-1:0]   az_zk;
  logic [3*MW-1:0]        az_mid;
  sda_flags_t             az_flags;

  // bridge
  logic                   br_valid, br_ready;
  sda_vec_t               br_vec;
  logic signed [AZ_W-1:0] br_az;
  logic [3*MW-1:0]        br_mid;
  sda_flags_t             br_flags;

  // polar cell row
  sda_vec_t          pl_vec [CORDIC_STAGES+1];
  logic [SB_POL-1:0] pl_sb  [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] pl_v, pl_r;
  logic signed [AZ_W-1:0] pl_az;
  logic [3*MW-1:0]        pl_mid;
  sda_flags_t             pl_flags;

  // output register
  logic                   out_v_q, out_ready;
  logic signed [AZ_W-1:0] pol_r;
  logic [POL_W-1:0]       pol_d, pol_q;
  logic signed [AZ_W-1:0] az_q;
  logic [3*MW-1:0]        mid_q;
  logic                   degen_q;

  sda_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .coords_i(s_axis_tdata_i[6*COORD_WIDTH-1:0]),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .vec_o   (fr_vec),
    .zk_o    (fr_zk),
    .mid_o   (fr_mid),
    .flags_o (fr_flags)
  );

  // azimuth CORDIC on (dx, dy)
  assign az_vec[0] = fr_vec;
  assign az_sb[0]  = {fr_zk, fr_mid, fr_flags};
  assign az_v[0]   = fr_valid;
  assign fr_ready  = az_r[0];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_az
    sda_cell #(
      .STAGE(g),
      .SB_W (SB_AZ)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(az_v[g]),
      .ready_o(az_r[g]),
      .vec_i  (az_vec[g]),
      .sb_i   (az_sb[g]),
      .valid_o(az_v[g+1]),
      .ready_i(az_r[g+1]),
      .vec_o  (az_vec[g+1]),
      .sb_o   (az_sb[g+1])
    );
  end

  assign {az_zk, az_mid, az_flags} = az_sb[CORDIC_STAGES];
  assign az_r[CORDIC_STAGES] = br_ready;

  sda_bridge #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_bridge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(az_v[CORDIC_STAGES]),
    .ready_o(br_ready),
    .vec_i  (az_vec[CORDIC_STAGES]),
    .zk_i   (az_zk),
    .mid_i  (az_mid),
    .flags_i(az_flags),
    .valid_o(br_valid),
    .ready_i(pl_r[0]),
    .vec_o  (br_vec),
    .az_o   (br_az),
    .mid_o  (br_mid),
    .flags_o(br_flags)
  );

  // polar CORDIC on (K*dz, rho)
  assign pl_vec[0] = br_vec;
  assign pl_sb[0]  = {br_az, br_mid, br_flags};
  assign pl_v[0]   = br_valid;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_pl
    sda_cell #(
      .STAGE(g),
      .SB_W (SB_POL)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(pl_v[g]),
      .ready_o(pl_r[g]),
      .vec_i  (pl_vec[g]),
      .sb_i   (pl_sb[g]),
      .valid_o(pl_v[g+1]),
      .ready_i(pl_r[g+1]),
      .vec_o  (pl_vec[g+1]),
      .sb_o   (pl_sb[g+1])
    );
  end

  assign {pl_az, pl_mid, pl_flags} = pl_sb[CORDIC_STAGES];
  assign pl_r[CORDIC_STAGES] = out_ready;

  // polar: round, clamp to 0..180 degrees, z-axis and zero-length cases
  always_comb begin
    pol_r = round_deg(pl_vec[CORDIC_STAGES].z);
    if (pl_flags.degen) begin
      pol_d = '0;
    end else if (pl_flags.axis) begin
      pol_d = pl_flags.dzneg ? POL_MAX : '0;
    end else if (pol_r[AZ_W-1]) begin
      pol_d = '0;
    end else if (pol_r > AZ_MAX) begin
      pol_d = POL_MAX;
    end else begin
      pol_d = POL_W'(pol_r);
    end
  end

  assign out_ready = !out_v_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= pl_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && pl_v[CORDIC_STAGES]) begin
      pol_q   <= pol_d;
      az_q    <= pl_az;
      mid_q   <= pl_mid;
      degen_q <= pl_flags.degen;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = OUT_DW'({pol_q, az_q, mid_q});
  assign m_axis_tuser_o  = degen_q;

`ifndef ASSERT_OFF
  // with the output register empty, the whole ready chain must be open
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> s_axis_tready_o)
    else $error("input stalled while output register empty");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && degen_q) |-> ((az_q == '0) && (pol_q == '0)))
    else $error("zero-length segment with nonzero angle");

  a_polar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (pol_q <= POL_MAX))
    else $error("polar angle out of range");

  a_az_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> ((az_q >= AZ_MIN) && (az_q <= AZ_MAX)))
    else $error("azimuth out of range");
`endif

endmodule

// ----- rtl/sda_front.sv -----
`timescale 1ns / 1ps

module sda_front #(
  parameter int COORD_WIDTH = sda_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [6*COORD_WIDTH-1:0]        coords_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output sda_pkg::sda_vec_t               vec_o,
  output logic signed [sda_pkg::XW-1:0]   zk_o,
  output logic [3*(COORD_WIDTH+1)-1:0]    mid_o,
  output sda_pkg::sda_flags_t             flags_o
);
  import sda_pkg::*;

  localparam int DW   = COORD_WIDTH + 1;
  localparam int PW   = $clog2(DW);
  localparam int NSTG = 5;

  logic [NSTG-1:0] v_q, v_in, rdy, ld;

  // stage A: differences and sums
  logic signed [DW-1:0] d_a_d [3];
  logic signed [DW-1:0] d_a_q [3];
  logic [3*DW-1:0]      mid_a_d, mid_a_q;
  // stage B: OR of magnitudes, flags
  logic signed [DW-1:0] d_b_q [3];
  logic [3*DW-1:0]      mid_b_q;
  logic [DW-1:0]        mag_b_d, mag_b_q;
  sda_flags_t           flags_b_d, flags_b_q;
  // stage C: normalize shift amounts
  logic signed [DW-1:0] d_c_q [3];
  logic [3*DW-1:0]      mid_c_q;
  sda_flags_t           flags_c_q;
  logic [PW-1:0]        lead;
  logic [4:0]           shl_c_d, shl_c_q;
  logic [1:0]           shr_c_d, shr_c_q;
  // stage D: normalized direction
  logic signed [NW-1:0] n_d_d [3];
  logic signed [NW-1:0] n_d_q [3];
  logic [3*DW-1:0]      mid_d_q;
  sda_flags_t           flags_d_q;
  // stage E: pre-rotation and gain-scaled dz
  logic signed [NW+17:0] prod;
  sda_vec_t              vec_e_q;
  logic signed [XW-1:0]  zk_e_q;
  logic [3*DW-1:0]       mid_e_q;
  sda_flags_t            flags_e_q;

  // backward ready chain: a stage moves when empty or when its successor moves
  always_comb begin
    rdy[NSTG-1] = !v_q[NSTG-1] || ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign v_in    = {v_q[NSTG-2:0], valid_i};
  assign ld      = rdy & v_in;
  assign ready_o = rdy[0];
  assign valid_o = v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // stage A logic
  always_comb begin
    logic signed [COORD_WIDTH-1:0] ca, cb;
    for (int j = 0; j < 3; j++) begin
      ca = coords_i[j*COORD_WIDTH +: COORD_WIDTH];
      cb = coords_i[(j+3)*COORD_WIDTH +: COORD_WIDTH];
      d_a_d[j]           = DW'(ca) - DW'(cb);
      mid_a_d[j*DW +: DW] = DW'(ca) + DW'(cb);
    end
  end

  // stage B logic: leading one of the max equals leading one of the OR
  always_comb begin
    mag_b_d = '0;
    for (int j = 0; j < 3; j++) begin
      mag_b_d = mag_b_d | (d_a_q[j][DW-1] ? DW'(-d_a_q[j]) : DW'(d_a_q[j]));
    end
    flags_b_d.axis  = (d_a_q[0] == '0) && (d_a_q[1] == '0);
    flags_b_d.degen = flags_b_d.axis && (d_a_q[2] == '0);
    flags_b_d.dzneg = d_a_q[2][DW-1];
  end

  // stage C logic: priority encode, split into left or right shift
  always_comb begin
    lead = '0;
    for (int i = 0; i < DW; i++) begin
      if (mag_b_q[i]) begin
        lead = PW'(i);
      end
    end
    if (int'(lead) <= NORM_TOP) begin
      shl_c_d = 5'(NORM_TOP - int'(lead));
      shr_c_d = '0;
    end else begin
      shl_c_d = '0;
      shr_c_d = 2'(int'(lead) - NORM_TOP);
    end
  end

  // stage D logic: top bit of the largest component lands on bit 30
  always_comb begin
    logic signed [XW-1:0] ext;
    for (int j = 0; j < 3; j++) begin
      ext      = XW'(d_c_q[j]);
      n_d_d[j] = NW'((ext <<< shl_c_q) >>> shr_c_q);
    end
  end

  // stage E logic: dz times the CORDIC gain
  assign prod = n_d_q[2] * $signed({1'b0, K_Q16});

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      d_a_q   <= d_a_d;
      mid_a_q <= mid_a_d;
    end
    if (ld[1]) begin
      d_b_q     <= d_a_q;
      mid_b_q   <= mid_a_q;
      mag_b_q   <= mag_b_d;
      flags_b_q <= flags_b_d;
    end
    if (ld[2]) begin
      d_c_q     <= d_b_q;
      mid_c_q   <= mid_b_q;
      flags_c_q <= flags_b_q;
      shl_c_q   <= shl_c_d;
      shr_c_q   <= shr_c_d;
    end
    if (ld[3]) begin
      n_d_q     <= n_d_d;
      mid_d_q   <= mid_c_q;
      flags_d_q <= flags_c_q;
    end
    if (ld[4]) begin
      vec_e_q   <= prerot(XW'(n_d_q[0]), XW'(n_d_q[1]));
      zk_e_q    <= XW'(prod >>> 16);
      mid_e_q   <= mid_d_q;
      flags_e_q <= flags_d_q;
    end
  end

  assign vec_o   = vec_e_q;
  assign zk_o    = zk_e_q;
  assign mid_o   = mid_e_q;
  assign flags_o = flags_e_q;

endmodule

// ----- rtl/sda_cell.sv -----
`timescale 1ns / 1ps

module sda_cell #(
  parameter int STAGE = 0,
  parameter int SB_W  = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  sda_pkg::sda_vec_t vec_i,
  input  logic [SB_W-1:0]   sb_i,
  output logic              valid_o,
  input  logic              ready_i,
  output sda_pkg::sda_vec_t vec_o,
  output logic [SB_W-1:0]   sb_o
);
  import sda_pkg::*;

  logic                 v_q;
  sda_vec_t             vec_d, vec_q;
  logic [SB_W-1:0]      sb_q;
  logic signed [XW-1:0] xs, ys;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;

  // one vectoring micro-rotation, driving y toward zero
  always_comb begin
    xs = vec_i.x >>> STAGE;
    ys = vec_i.y >>> STAGE;
    if (!vec_i.y[XW-1]) begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + ATAN_TAB[STAGE];
    end else begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      vec_q <= vec_d;
      sb_q  <= sb_i;
    end
  end

  assign vec_o = vec_q;
  assign sb_o  = sb_q;

endmodule

// ----- rtl/sda_bridge.sv -----
`timescale 1ns / 1ps

module sda_bridge #(
  parameter int COORD_WIDTH = sda_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  sda_pkg::sda_vec_t               vec_i,
  input  logic signed [sda_pkg::XW-1:0]   zk_i,
  input  logic [3*(COORD_WIDTH+1)-1:0]    mid_i,
  input  sda_pkg::sda_flags_t             flags_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output sda_pkg::sda_vec_t               vec_o,
  output logic signed [sda_pkg::AZ_W-1:0] az_o,
  output logic [3*(COORD_WIDTH+1)-1:0]    mid_o,
  output sda_pkg::sda_flags_t             flags_o
);
  import sda_pkg::*;

  logic                   v_q;
  logic signed [AZ_W-1:0] az_r, az_d, az_q;
  sda_vec_t               vec_q;
  logic [3*(COORD_WIDTH+1)-1:0] mid_q;
  sda_flags_t             flags_q;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;

  // azimuth: round, clamp, zero along the z axis
  always_comb begin
    az_r = round_deg(vec_i.z);
    if (flags_i.axis) begin
      az_d = '0;
    end else if (az_r > AZ_MAX) begin
      az_d = AZ_MAX;
    end else if (az_r < AZ_MIN) begin
      az_d = AZ_MIN;
    end else begin
      az_d = az_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  // polar vector is (K*dz, rho), rho being the azimuth CORDIC's final x
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      vec_q   <= prerot(zk_i, vec_i.x);
      az_q    <= az_d;
      mid_q   <= mid_i;
      flags_q <= flags_i;
    end
  end

  assign vec_o   = vec_q;
  assign az_o    = az_q;
  assign mid_o   = mid_q;
  assign flags_o = flags_q;

endmodule

// ----- test/segment_direction_monitor.sv -----
`timescale 1ns / 1ps

// Watches both streams of the segment unit, works out the midpoint sums and
// the two direction angles of every accepted segment and compares them with
// the results in arrival order.
module segment_direction_monitor #(
  parameter int CW     = sda_pkg::COORD_WIDTH_DEF,
  parameter int STAGES = sda_pkg::CORDIC_STAGES_DEF,
  parameter int IN_DW  = ((6 * CW + 7) / 8) * 8,
  parameter int OUT_DW = ((3 * (CW + 1) + sda_pkg::AZ_W + sda_pkg::POL_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [IN_DW-1:0]  s_tdata_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [OUT_DW-1:0] m_tdata_i,
  input  logic              m_tuser_i,
  output int                segs_o,
  output int                results_o,
  output int                errors_o
);
  import sda_pkg::*;

  localparam int MW     = CW + 1;
  localparam int AZ_LSB = 3 * MW;
  localparam int PL_LSB = AZ_LSB + AZ_W;

  typedef struct packed {
    logic signed [MW-1:0]   mid_x;
    logic signed [MW-1:0]   mid_y;
    logic signed [MW-1:0]   mid_z;
    logic signed [AZ_W-1:0] azimuth;
    logic [POL_W-1:0]       polar;
    logic                   degenerate;
  } dir_result_t;

  dir_result_t pending_dirs[$];

  // vectoring CORDIC: returns the angle of (x0,y0) in 1/32768 degree
  function automatic longint vector_angle(input longint x0, input longint y0,
                                          output longint x_out);
    longint x, y, z, nx, ny;
    int i;
    x = x0;
    y = y0;
    z = 0;
    // fold the left half plane over by a quarter turn
    if (x < 0) begin
      if (y >= 0) begin
        x = y0;
        y = -x0;
        z = longint'(DEG90);
      end else begin
        x = -y0;
        y = x0;
        z = -longint'(DEG90);
      end
    end
    for (i = 0; i < STAGES && i < TAB_LEN; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + longint'(ATAN_TAB[i]);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - longint'(ATAN_TAB[i]);
      end
      x = nx;
      y = ny;
    end
    x_out = x;
    return z;
  endfunction

  // 1/32768 degree -> 1/128 degree, round half up, then clamp
  function automatic longint to_angle(input longint z, input longint lo, input longint hi);
    longint r;
    r = (z + 128) >>> 8;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic dir_result_t predict_direction(input logic [IN_DW-1:0] seg);
    dir_result_t r;
    longint a, b, m, rho, spare_x, zk;
    longint d[3], n[3], sum[3];
    int j, p, sh;
    m = 0;
    for (j = 0; j < 3; j++) begin
      a      = longint'($signed(seg[j*CW +: CW]));
      b      = longint'($signed(seg[(j+3)*CW +: CW]));
      d[j]   = a - b;
      sum[j] = a + b;
      if ((d[j] < 0 ? -d[j] : d[j]) > m) m = d[j] < 0 ? -d[j] : d[j];
    end
    r.mid_x      = MW'(sum[0]);
    r.mid_y      = MW'(sum[1]);
    r.mid_z      = MW'(sum[2]);
    r.azimuth    = '0;
    r.polar      = '0;
    r.degenerate = (m == 0);
    if (m != 0) begin
      // bring the largest component to [2^30, 2^31)
      p = 0;
      while (p < 63 && (m >> (p + 1)) != 0) p++;
      sh = NORM_TOP - p;
      for (j = 0; j < 3; j++) n[j] = (sh >= 0) ? (d[j] <<< sh) : (d[j] >>> (-sh));
      if (d[0] == 0 && d[1] == 0) begin
        // straight up or down the z axis
        r.polar = (d[2] > 0) ? '0 : POL_MAX;
      end else begin
        r.azimuth = AZ_W'(to_angle(vector_angle(n[0], n[1], rho),
                                   longint'(AZ_MIN), longint'(AZ_MAX)));
        zk = (n[2] * longint'(K_Q16)) >>> 16;
        r.polar = POL_W'(to_angle(vector_angle(zk, rho, spare_x), 0, longint'(POL_MAX)));
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors_o++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // sample both channels on the rising edge; counters clear under reset
  always @(posedge clk_i) begin
    dir_result_t want;
    if (!rst_ni) begin
      segs_o    = 0;
      results_o = 0;
      errors_o  = 0;
      pending_dirs.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        pending_dirs = {pending_dirs, predict_direction(s_tdata_i)};
        segs_o++;
      end
      if (m_tvalid_i && m_tready_i) begin
        results_o++;
        if (pending_dirs.size() == 0) begin
          errors_o++;
          $error("result transaction with no segment outstanding");
        end else begin
          want = pending_dirs.pop_front();
          check_field("mid_x", want.mid_x, $signed(m_tdata_i[0 +: MW]));
          check_field("mid_y", want.mid_y, $signed(m_tdata_i[MW +: MW]));
          check_field("mid_z", want.mid_z, $signed(m_tdata_i[2*MW +: MW]));
          check_field("azimuth", want.azimuth, $signed(m_tdata_i[AZ_LSB +: AZ_W]));
          check_field("polar", want.polar, m_tdata_i[PL_LSB +: POL_W]);
          check_field("degenerate", want.degenerate, m_tuser_i);
        end
      end
    end
  end

endmodule

// ----- test/segment_direction_angles_unit_tb.sv -----
`timescale 1ns / 1ps

module segment_direction_angles_unit_tb;

  localparam int CW     = sda_pkg::COORD_WIDTH_DEF;
  localparam int IN_DW  = ((6 * CW + 7) / 8) * 8;
  localparam int OUT_DW = ((3 * (CW + 1) + sda_pkg::AZ_W + sda_pkg::POL_W + 7) / 8) * 8;
  localparam int RANDOM_SEGS = 900;
  localparam int HOLD_CYCLES = 400;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_DW-1:0]  s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_DW-1:0] m_tdata;
  logic              m_tuser;

  int  segs, results, errors;
  int  burst_left = 0;
  int  n_degen = 0;
  int  n_axis = 0;
  bit  hold_go = 1'b0;

  always #1 clk_i = ~clk_i;

  segment_direction_angles_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  segment_direction_monitor u_monitor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid),
    .s_tready_i(s_tready),
    .s_tdata_i (s_tdata),
    .m_tvalid_i(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_i (m_tdata),
    .m_tuser_i (m_tuser),
    .segs_o    (segs),
    .results_o (results),
    .errors_o  (errors)
  );

  function automatic coord_t rand_coord();
    return coord_t'($urandom());
  endfunction

  function automatic coord_t rand_extreme();
    case ($urandom_range(0, 4))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      3:       return '1;
      default: return rand_coord();
    endcase
  endfunction

  // offer one segment; called and returning at a falling edge
  task automatic offer_segment(input coord_t fp [3], input coord_t sp [3]);
    logic [IN_DW-1:0] word;
    int gap, j;
    word = '0;
    for (j = 0; j < 3; j++) begin
      word[j*CW +: CW]     = fp[j];
      word[(j+3)*CW +: CW] = sp[j];
    end
    s_tvalid = 1'b1;
    s_tdata  = word;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
    // bursts of random length separated by random gaps
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic offer_points(input coord_t fx, input coord_t fy, input coord_t fz,
                              input coord_t sx, input coord_t sy, input coord_t sz);
    coord_t fp [3];
    coord_t sp [3];
    fp = '{fx, fy, fz};
    sp = '{sx, sy, sz};
    offer_segment(fp, sp);
  endtask

  // receiver: stretches of differing stall behavior, plus one long hold-off
  initial begin
    int mode, len, period, cnt;
    bit hold_done;
    hold_done = 1'b0;
    cnt = 0;
    wait (rst_ni);
    forever begin
      mode   = $urandom_range(0, 3);
      len    = $urandom_range(32, 256);
      period = $urandom_range(2, 4);
      repeat (len) begin
        @(negedge clk_i);
        cnt++;
        if (hold_go && !hold_done) begin
          m_tready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          hold_done = 1'b1;
        end
        case (mode)
          0:       m_tready = 1'b1;
          1:       m_tready = 1'($urandom_range(0, 1));
          2:       m_tready = (cnt % period) == 0;
          default: m_tready = $urandom_range(0, 9) != 0;
        endcase
      end
    end
  end

  // stimulus and verdict
  initial begin
    coord_t fp [3];
    coord_t sp [3];
    int k, j, kind, span, axes;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero-length segments, with the midpoint at zero and at both extremes
    offer_points('0, '0, '0, '0, '0, '0);
    offer_points(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    offer_points(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    // largest direction vectors, both signs
    offer_points(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
    offer_points(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    offer_points(C_MAX, '0, C_MIN, C_MIN, '0, C_MAX);
    offer_points(C_MAX, C_MIN, '0, C_MIN, C_MAX, C_MAX);
    // along the z axis, up and down
    offer_points('0, '0, 1, '0, '0, '0);
    offer_points('0, '0, '0, '0, '0, 1);
    offer_points('0, '0, C_MIN, '0, '0, C_MAX);
    offer_points(5, -7, C_MAX, 5, -7, C_MIN);
    // every quadrant of the azimuth, incl. the quarter-turn fold
    offer_points(1, '0, '0, '0, '0, '0);
    offer_points(-1, '0, '0, '0, '0, '0);
    offer_points(-5, -3, '0, '0, '0, '0);
    offer_points(-5, 3, 7, '0, '0, '0);
    offer_points('0, 1, '0, '0, '0, '0);
    offer_points('0, -1, '0, '0, '0, '0);
    offer_points(C_MAX, C_MAX, '0, '0, '0, '0);
    offer_points(1, 1, 1, '0, '0, '0);
    offer_points(-1, -1, -1, '0, '0, '0);
    offer_points(3, -4, -12, '0, '0, '0);
    n_degen = 3;
    n_axis  = 4;

    for (k = 0; k < RANDOM_SEGS; k++) begin
      if (k == RANDOM_SEGS / 3) hold_go = 1'b1;
      kind = $urandom_range(0, 99);
      for (j = 0; j < 3; j++) begin
        fp[j] = rand_coord();
        sp[j] = rand_coord();
      end
      if (kind < 35) begin
        // fully random end points
      end else if (kind < 60) begin
        // short segments at random places
        span = 1 << $urandom_range(0, 16);
        for (j = 0; j < 3; j++) sp[j] = fp[j] + coord_t'(int'($urandom_range(0, 2 * span)) - span);
      end else if (kind < 75) begin
        // some direction components forced to zero
        axes = $urandom_range(1, 6);
        for (j = 0; j < 3; j++) if (!axes[j]) sp[j] = fp[j];
        if (axes == 4) n_axis++;
      end else if (kind < 80) begin
        sp = fp;
        n_degen++;
      end else begin
        for (j = 0; j < 3; j++) begin
          fp[j] = rand_extreme();
          sp[j] = rand_extreme();
        end
      end
      offer_segment(fp, sp);
    end
    s_tvalid = 1'b0;

    while (results < segs) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("Sent %0d segments (%0d forced zero-length, %0d along z) with bursty input,",
             segs, n_degen, n_axis);
    $display("stalled output and one %0d-cycle hold-off; %0d results checked.",
             HOLD_CYCLES, results);
    if (errors == 0 && results == segs) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sda_pkg.sv
rtl/sda_front.sv
rtl/sda_cell.sv
rtl/sda_bridge.sv
rtl/segment_direction_angles_unit.sv
test/segment_direction_monitor.sv
test/segment_direction_angles_unit_tb.sv
